@@ hdl/wcd_pkg.sv @@
// Shared types and constants of the wake and command decider.
`timescale 1ns / 1ps

package wcd_pkg;

    localparam int NUM_LABELS   = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [15:0] WEAK_MIN        = 16'd787;
    localparam logic [15:0] WEAK_FAST       = 16'd4588;
    localparam logic [15:0] WEAK_PEAK       = 16'd2294;
    localparam logic [19:0] WEAK_SUM        = 20'd3605;
    localparam logic [19:0] WEAK_SUM_MAX    = 20'hFFFFF;
    localparam logic [15:0] FAST_CONF       = 16'd49152;
    localparam logic [15:0] EARLY_FAST_CONF = 16'd38011;

    localparam logic [15:0] WEAK_HOLD_MS     = 16'd650;
    localparam logic [15:0] CMD_HOLD_MS      = 16'd550;
    localparam logic [15:0] EXPIRE_MS        = 16'd600;
    localparam logic [15:0] POST_EXIT_MS     = 16'd800;
    localparam logic [15:0] DECISION_MS      = 16'd250;
    localparam logic [15:0] FAST_DECISION_MS = 16'd80;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WAKE_CONFIRM  = 3'd0,
        CFG_CMD_CONFIRM   = 3'd1,
        CFG_COOLDOWN      = 3'd2,
        CFG_LISTEN_WINDOW = 3'd3,
        CFG_MIN_RMS       = 3'd4,
        CFG_FAST_LABEL    = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_WAKE    = 3'd1,
        EV_REFRESH = 3'd2,
        EV_TIMEOUT = 3'd3,
        EV_FIRED   = 3'd4
    } t_event;

    typedef struct packed {
        logic [3:0]  wake_confirm_frames;
        logic [3:0]  command_confirm_frames;
        logic [15:0] cooldown_ms;
        logic [15:0] listen_window_ms;
        logic [15:0] min_rms_level;
        logic [3:0]  fast_label;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        wake_confirm_frames:    4'd2,
        command_confirm_frames: 4'd2,
        cooldown_ms:            16'd500,
        listen_window_ms:       16'd5000,
        min_rms_level:          16'd100,
        fast_label:             4'd0
    };

    typedef struct packed {
        logic [31:0] now_ms;
        logic        has_result;
        logic        is_wake_word;
        logic [15:0] wake_score;
        logic        has_command;
        logic [3:0]  command_label;
        logic [3:0]  command_action;
        logic [15:0] command_score;
        logic [15:0] audio_rms;
    } t_in_item;

    typedef struct packed {
        logic       wake_active;
        t_event     event_code;
        logic [3:0] fired_action;
        logic       deferred_pending;
    } t_result;

endpackage

@@ hdl/wcd_stream_if.sv @@
// Valid/ready channel interfaces for classifier frames and decider results.
`timescale 1ns / 1ps

interface wcd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        has_result;
    logic        is_wake_word;
    logic [15:0] wake_score;
    logic        has_command;
    logic [3:0]  command_label;
    logic [3:0]  command_action;
    logic [15:0] command_score;
    logic [15:0] audio_rms;

    modport source (
        output valid, now_ms, has_result, is_wake_word, wake_score, has_command,
               command_label, command_action, command_score, audio_rms,
        input  ready
    );
    modport sink (
        input  valid, now_ms, has_result, is_wake_word, wake_score, has_command,
               command_label, command_action, command_score, audio_rms,
        output ready
    );
endinterface

interface wcd_out_if;
    logic       valid;
    logic       ready;
    logic       wake_active;
    logic [2:0] event_code;
    logic [3:0] fired_action;
    logic       deferred_pending;

    modport source (
        output valid, wake_active, event_code, fired_action, deferred_pending,
        input  ready
    );
    modport sink (
        input  valid, wake_active, event_code, fired_action, deferred_pending,
        output ready
    );
endinterface

@@ hdl/wcd_cfg_regs.sv @@
// Configuration register file of the wake and command decider.
`timescale 1ns / 1ps

module wcd_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wcd_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [15:0]                       i_cfg_wdata,
    output wcd_pkg::t_cfg                     o_cfg
);
    import wcd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WAKE_CONFIRM:  r_cfg.wake_confirm_frames    <= i_cfg_wdata[3:0];
                CFG_CMD_CONFIRM:   r_cfg.command_confirm_frames <= i_cfg_wdata[3:0];
                CFG_COOLDOWN:      r_cfg.cooldown_ms            <= i_cfg_wdata;
                CFG_LISTEN_WINDOW: r_cfg.listen_window_ms       <= i_cfg_wdata;
                CFG_MIN_RMS:       r_cfg.min_rms_level          <= i_cfg_wdata;
                CFG_FAST_LABEL:    r_cfg.fast_label             <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/wcd_core.sv @@
// Decision state and the combinational update logic for one frame or tick.
`timescale 1ns / 1ps

module wcd_core #(
    parameter int TIME_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  wcd_pkg::t_cfg     i_cfg,
    input  wcd_pkg::t_in_item i_item,
    output wcd_pkg::t_result  o_res
);
    import wcd_pkg::*;

    localparam int TB = TIME_BITS;

    typedef logic [TB-1:0] t_time;

    typedef struct packed {
        logic        listening;
        t_time       wake_start_time;
        t_time       last_exit_time;
        logic [3:0]  wake_run_frames;
        logic [19:0] weak_sum;
        logic [15:0] weak_peak;
        t_time       weak_last_time;
        logic [7:0]  weak_frames;
        logic        cand_label_valid;
        logic [3:0]  cand_label;
        logic [3:0]  cand_action;
        logic [3:0]  cand_frames;
        t_time       cand_last_time;
        logic        defer_valid;
        logic [3:0]  defer_action;
        t_time       defer_ready_time;
        t_time       defer_expire_time;
    } t_st;

    function automatic t_time tdiff(t_time a, t_time b);
        return a - b;
    endfunction

    function automatic logic reached(t_time a, t_time b);
        t_time d;
        d = a - b;
        return !d[TB-1];
    endfunction

    function automatic t_st clr_weak(t_st x);
        x.weak_sum       = '0;
        x.weak_peak      = '0;
        x.weak_last_time = '0;
        x.weak_frames    = '0;
        return x;
    endfunction

    function automatic t_st clr_cand(t_st x);
        x.cand_label_valid = 1'b0;
        x.cand_label       = '0;
        x.cand_action      = '0;
        x.cand_frames      = '0;
        x.cand_last_time   = '0;
        return x;
    endfunction

    function automatic t_st clr_defer(t_st x);
        x.defer_valid       = 1'b0;
        x.defer_action      = '0;
        x.defer_ready_time  = '0;
        x.defer_expire_time = '0;
        return x;
    endfunction

    function automatic t_st clr_all(t_st x);
        x.wake_run_frames = '0;
        return clr_defer(clr_cand(clr_weak(x)));
    endfunction

    t_st         r_st;
    t_st         n_st;
    t_event      ev;
    logic [3:0]  fired;
    t_time       now;
    logic        has_cmd;
    logic        fast_label_hit;
    logic        wr_hit;
    logic        wk_hit;
    logic        cand_hit;
    logic [20:0] wsum;
    logic        dreq;
    logic        dfast;
    logic [3:0]  dact;
    t_time       cool_time;
    t_time       dec_fast;
    t_time       dec_slow;
    t_time       rdy_fast;
    t_time       rdy_slow;
    t_time       rdy;

    assign now            = i_item.now_ms[TB-1:0];
    assign has_cmd        = i_item.has_command && (int'(i_item.command_label) < NUM_LABELS);
    assign fast_label_hit = has_cmd && (i_item.command_label == i_cfg.fast_label);

    // The ready time is the later of the cooldown end and the decision delay.
    assign cool_time = r_st.wake_start_time + TB'(i_cfg.cooldown_ms);
    assign dec_fast  = now + TB'(FAST_DECISION_MS);
    assign dec_slow  = now + TB'(DECISION_MS);
    assign rdy_fast  = (dec_fast > cool_time) ? dec_fast : cool_time;
    assign rdy_slow  = (dec_slow > cool_time) ? dec_slow : cool_time;
    assign rdy       = dfast ? rdy_fast : rdy_slow;

    always_comb begin
        n_st     = r_st;
        ev       = EV_NONE;
        fired    = '0;
        wr_hit   = 1'b0;
        wk_hit   = 1'b0;
        cand_hit = 1'b0;
        wsum     = '0;
        dreq     = 1'b0;
        dfast    = 1'b0;
        dact     = '0;

        if (n_st.listening &&
            (tdiff(now, n_st.wake_start_time) >= TB'(i_cfg.listen_window_ms))) begin
            n_st                = clr_all(n_st);
            n_st.listening      = 1'b0;
            n_st.last_exit_time = now;
            ev                  = EV_TIMEOUT;
        end

        if (i_item.has_result) begin
            if (i_item.audio_rms < i_cfg.min_rms_level) begin
                if (n_st.defer_valid && reached(now, n_st.defer_expire_time)) begin
                    n_st = clr_defer(n_st);
                end
                if ((n_st.weak_frames != 8'd0) &&
                    (tdiff(now, n_st.weak_last_time) > TB'(WEAK_HOLD_MS))) begin
                    n_st = clr_weak(n_st);
                end
            end else if (!n_st.listening) begin
                if ((n_st.last_exit_time != '0) &&
                    (tdiff(now, n_st.last_exit_time) < TB'(POST_EXIT_MS))) begin
                    n_st.wake_run_frames = '0;
                    n_st                 = clr_weak(n_st);
                end else begin
                    if (!i_item.is_wake_word) begin
                        n_st.wake_run_frames = '0;
                    end else if (n_st.wake_run_frames == 4'd0) begin
                        n_st.wake_run_frames = 4'd1;
                        wr_hit = (i_cfg.wake_confirm_frames <= 4'd1);
                    end else begin
                        if (n_st.wake_run_frames < i_cfg.wake_confirm_frames) begin
                            n_st.wake_run_frames = n_st.wake_run_frames + 4'd1;
                        end
                        wr_hit = (n_st.wake_run_frames >= i_cfg.wake_confirm_frames);
                    end
                    if (!wr_hit) begin
                        if ((n_st.weak_frames != 8'd0) &&
                            (tdiff(now, n_st.weak_last_time) > TB'(WEAK_HOLD_MS))) begin
                            n_st = clr_weak(n_st);
                        end
                        if (i_item.wake_score >= WEAK_MIN) begin
                            wsum = {1'b0, n_st.weak_sum} + 21'(i_item.wake_score);
                            n_st.weak_sum = wsum[20] ? WEAK_SUM_MAX : wsum[19:0];
                            if (i_item.wake_score > n_st.weak_peak) begin
                                n_st.weak_peak = i_item.wake_score;
                            end
                            n_st.weak_last_time = now;
                            if (n_st.weak_frames != 8'hFF) begin
                                n_st.weak_frames = n_st.weak_frames + 8'd1;
                            end
                        end
                        wk_hit = (i_item.wake_score >= WEAK_FAST) ||
                                 ((n_st.weak_frames >= 8'd2) &&
                                  (n_st.weak_peak >= WEAK_PEAK) &&
                                  (n_st.weak_sum >= WEAK_SUM));
                    end
                    if (wr_hit || wk_hit) begin
                        n_st                 = clr_all(n_st);
                        n_st.listening       = 1'b1;
                        n_st.wake_start_time = now;
                        ev                   = EV_WAKE;
                    end
                end
            end else if (tdiff(now, n_st.wake_start_time) < TB'(i_cfg.cooldown_ms)) begin
                n_st = clr_cand(n_st);
                if (fast_label_hit && (i_item.command_score >= EARLY_FAST_CONF)) begin
                    dreq  = 1'b1;
                    dfast = 1'b1;
                    dact  = i_item.command_action;
                end
            end else begin
                if (n_st.defer_valid && reached(now, n_st.defer_expire_time)) begin
                    n_st = clr_defer(n_st);
                end
                if (n_st.defer_valid && reached(now, n_st.defer_ready_time)) begin
                    fired               = n_st.defer_action;
                    n_st                = clr_all(n_st);
                    n_st.listening      = 1'b0;
                    n_st.last_exit_time = now;
                    ev                  = EV_FIRED;
                end else if (i_item.is_wake_word) begin
                    n_st                 = clr_all(n_st);
                    n_st.listening       = 1'b1;
                    n_st.wake_start_time = now;
                    ev                   = EV_REFRESH;
                end else if (fast_label_hit && (i_item.command_score >= FAST_CONF)) begin
                    dreq  = 1'b1;
                    dfast = 1'b1;
                    dact  = i_item.command_action;
                end else if (!n_st.defer_valid) begin
                    if (!has_cmd) begin
                        if ((n_st.cand_frames != 4'd0) &&
                            (tdiff(now, n_st.cand_last_time) > TB'(CMD_HOLD_MS))) begin
                            n_st = clr_cand(n_st);
                        end
                    end else if (!n_st.cand_label_valid ||
                                 (n_st.cand_label != i_item.command_label)) begin
                        n_st.cand_label_valid = 1'b1;
                        n_st.cand_label       = i_item.command_label;
                        n_st.cand_action      = i_item.command_action;
                        n_st.cand_frames      = 4'd1;
                        n_st.cand_last_time   = now;
                        cand_hit = (i_cfg.command_confirm_frames <= 4'd1);
                    end else begin
                        if (n_st.cand_frames < i_cfg.command_confirm_frames) begin
                            n_st.cand_frames = n_st.cand_frames + 4'd1;
                        end
                        n_st.cand_action    = i_item.command_action;
                        n_st.cand_last_time = now;
                        cand_hit = (n_st.cand_frames >= i_cfg.command_confirm_frames);
                    end
                    if (cand_hit) begin
                        dreq = 1'b1;
                        dact = n_st.cand_action;
                    end
                end
            end
        end

        if (dreq) begin
            n_st.defer_valid       = 1'b1;
            n_st.defer_action      = dact;
            n_st.defer_ready_time  = rdy;
            n_st.defer_expire_time = rdy + TB'(EXPIRE_MS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    assign o_res.wake_active      = n_st.listening;
    assign o_res.event_code       = ev;
    assign o_res.fired_action     = fired;
    assign o_res.deferred_pending = n_st.defer_valid;

    a_wake_enters_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (o_res.event_code == EV_WAKE) |=> r_st.listening && !r_st.defer_valid)
        else $error("wake did not enter a clean listening state");

    a_defer_needs_listen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.defer_valid |-> r_st.listening)
        else $error("deferred command pending outside listening mode");

    a_hold_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_st))
        else $error("decision state changed without a beat");

    a_fire_leaves_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (o_res.event_code == EV_FIRED)
        |=> !r_st.listening && !r_st.defer_valid && (r_st.cand_frames == 4'd0))
        else $error("firing a command did not leave listening mode");

endmodule

@@ hdl/wake_and_command_decider.sv @@
// Top level of the wake and command decider: input register, decision core, result register.
//
//   Channel   Direction  Handshake     Contents
//   i_in      sink       valid/ready   frame or tick with millisecond timestamp
//   o_out     source     valid/ready   mode, event, fired action, pending flag
//   i_cfg_*   sink       write enable  register index and data, no read-back
//
// One beat is accepted per cycle when the output is taken; a result passes through the
// input and result registers. The rate is set by the combinational state update.
// Reset is synchronous and clears the configuration to defaults and the decision state.
// A stalled result holds in the output register; the input register then fills
// and ready drops until the output moves.
`timescale 1ns / 1ps

module wake_and_command_decider #(
    parameter int TIME_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wcd_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [15:0]                      i_cfg_wdata,
    wcd_in_if.sink                           i_in,
    wcd_out_if.source                        o_out
);
    import wcd_pkg::*;

    t_cfg     cfg;
    t_result  res;
    logic     adv;
    logic     r_in_valid;
    t_in_item r_in;
    logic     r_out_valid;
    t_result  r_out;

    wcd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.now_ms         <= i_in.now_ms;
            r_in.has_result     <= i_in.has_result;
            r_in.is_wake_word   <= i_in.is_wake_word;
            r_in.wake_score     <= i_in.wake_score;
            r_in.has_command    <= i_in.has_command;
            r_in.command_label  <= i_in.command_label;
            r_in.command_action <= i_in.command_action;
            r_in.command_score  <= i_in.command_score;
            r_in.audio_rms      <= i_in.audio_rms;
        end
    end

    wcd_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_cfg   (cfg),
        .i_item  (r_in),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.wake_active      = r_out.wake_active;
    assign o_out.event_code       = r_out.event_code;
    assign o_out.fired_action     = r_out.fired_action;
    assign o_out.deferred_pending = r_out.deferred_pending;

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled while the result register is empty");

    a_stalled_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid)
        else $error("a waiting input beat was dropped");

endmodule

@@ dv/wcd_decision_checker.sv @@
// Checker that predicts every decider result from the accepted beats and compares them.
`timescale 1ns / 1ps

module wcd_decision_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wcd_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [15:0]                      i_cfg_wdata,
    wcd_in_if                                i_in,
    wcd_out_if                               i_out,
    output int                               o_fail_count,
    output int                               o_waiting
);
    import wcd_pkg::*;

    t_cfg        cfg = CFG_RESET;
    t_result     expected_results [$];
    int          fail_total = 0;

    logic        listening;
    logic [31:0] wake_start_ms;
    logic [31:0] exit_ms;
    logic [3:0]  wake_run;
    logic [19:0] weak_sum;
    logic [15:0] weak_peak;
    logic [31:0] weak_last_ms;
    logic [7:0]  weak_frames;
    logic        cand_valid;
    logic [3:0]  cand_label;
    logic [3:0]  cand_action;
    logic [3:0]  cand_frames;
    logic [31:0] cand_last_ms;
    logic        held_valid;
    logic [3:0]  held_action;
    logic [31:0] held_ready_ms;
    logic [31:0] held_expire_ms;

    t_in_item    seen_beat;
    t_result     got_result;
    t_result     want_result;

    assign o_fail_count = fail_total;

    function automatic logic [31:0] since(logic [31:0] now, logic [31:0] t);
        return now - t;
    endfunction

    function automatic logic due(logic [31:0] now, logic [31:0] t);
        logic [31:0] d;
        d = now - t;
        return !d[31];
    endfunction

    function automatic void clear_weak();
        weak_sum     = '0;
        weak_peak    = '0;
        weak_last_ms = '0;
        weak_frames  = '0;
    endfunction

    function automatic void clear_cand();
        cand_valid   = 1'b0;
        cand_label   = '0;
        cand_action  = '0;
        cand_frames  = '0;
        cand_last_ms = '0;
    endfunction

    function automatic void clear_held();
        held_valid     = 1'b0;
        held_action    = '0;
        held_ready_ms  = '0;
        held_expire_ms = '0;
    endfunction

    function automatic void clear_all();
        wake_run = '0;
        clear_weak();
        clear_cand();
        clear_held();
    endfunction

    function automatic void leave_listen(logic [31:0] now);
        listening = 1'b0;
        exit_ms   = now;
        clear_all();
    endfunction

    function automatic void enter_listen(logic [31:0] now);
        listening     = 1'b1;
        wake_start_ms = now;
        clear_all();
    endfunction

    function automatic void expire_held(logic [31:0] now);
        if (held_valid && due(now, held_expire_ms)) begin
            clear_held();
        end
    endfunction

    function automatic void weak_hold(logic [31:0] now);
        if (weak_frames != 0 && since(now, weak_last_ms) > WEAK_HOLD_MS) begin
            clear_weak();
        end
    endfunction

    function automatic logic held_due(logic [31:0] now);
        return held_valid && due(now, held_ready_ms);
    endfunction

    function automatic void hold_command(logic [3:0] action, logic [31:0] now,
                                         logic [15:0] delay);
        logic [31:0] cool;
        logic [31:0] dec;
        cool           = wake_start_ms + cfg.cooldown_ms;
        dec            = now + delay;
        held_valid     = 1'b1;
        held_action    = action;
        held_ready_ms  = (dec > cool) ? dec : cool;
        held_expire_ms = held_ready_ms + EXPIRE_MS;
    endfunction

    function automatic logic wake_run_step(logic is_wake);
        logic [3:0] need;
        need = cfg.wake_confirm_frames;
        if (!is_wake) begin
            wake_run = '0;
            return 1'b0;
        end
        if (wake_run == 0) begin
            wake_run = 4'd1;
            return need <= 1;
        end
        if (wake_run < need) begin
            wake_run++;
        end
        return wake_run >= need;
    endfunction

    function automatic logic weak_step(logic [31:0] now, logic [15:0] score);
        logic [20:0] total;
        weak_hold(now);
        if (score >= WEAK_MIN) begin
            total    = weak_sum + score;
            weak_sum = (total > WEAK_SUM_MAX) ? WEAK_SUM_MAX : total[19:0];
            if (score > weak_peak) begin
                weak_peak = score;
            end
            weak_last_ms = now;
            if (weak_frames != 8'd255) begin
                weak_frames++;
            end
        end
        if (score >= WEAK_FAST ||
            (weak_frames >= 2 && weak_peak >= WEAK_PEAK && weak_sum >= WEAK_SUM)) begin
            wake_run = '0;
            clear_weak();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic cand_step(logic [31:0] now, logic cmd_ok,
                                       logic [3:0] label, logic [3:0] action);
        logic [3:0] need;
        need = cfg.command_confirm_frames;
        if (!cmd_ok) begin
            if (cand_frames != 0 && since(now, cand_last_ms) > CMD_HOLD_MS) begin
                clear_cand();
            end
            return 1'b0;
        end
        if (!cand_valid || cand_label != label) begin
            cand_valid   = 1'b1;
            cand_label   = label;
            cand_action  = action;
            cand_frames  = 4'd1;
            cand_last_ms = now;
            return need <= 1;
        end
        if (cand_frames < need) begin
            cand_frames++;
        end
        cand_action  = action;
        cand_last_ms = now;
        return cand_frames >= need;
    endfunction

    function automatic logic run_command(t_in_item it, logic cmd_ok, output logic [3:0] fired);
        fired = '0;
        expire_held(it.now_ms);
        if (held_due(it.now_ms)) begin
            fired = held_action;
            leave_listen(it.now_ms);
            return 1'b1;
        end
        if (cmd_ok && it.command_label == cfg.fast_label && it.command_score >= FAST_CONF) begin
            hold_command(it.command_action, it.now_ms, FAST_DECISION_MS);
            return 1'b0;
        end
        if (held_valid) begin
            return 1'b0;
        end
        if (cand_step(it.now_ms, cmd_ok, it.command_label, it.command_action)) begin
            hold_command(cand_action, it.now_ms, DECISION_MS);
        end
        return 1'b0;
    endfunction

    function automatic t_result decide(t_in_item it);
        t_result     r;
        t_event      ev;
        logic [3:0]  fired;
        logic        cmd_ok;
        logic        woke;
        logic [31:0] now;
        now    = it.now_ms;
        ev     = EV_NONE;
        fired  = '0;
        cmd_ok = it.has_command && (int'(it.command_label) < NUM_LABELS);
        if (listening && since(now, wake_start_ms) >= cfg.listen_window_ms) begin
            leave_listen(now);
            ev = EV_TIMEOUT;
        end
        if (it.has_result) begin
            if (it.audio_rms < cfg.min_rms_level) begin
                expire_held(now);
                weak_hold(now);
            end else if (!listening) begin
                if (exit_ms != 0 && since(now, exit_ms) < POST_EXIT_MS) begin
                    wake_run = '0;
                    clear_weak();
                end else begin
                    woke = wake_run_step(it.is_wake_word);
                    if (!woke) begin
                        woke = weak_step(now, it.wake_score);
                    end
                    if (woke) begin
                        enter_listen(now);
                        ev = EV_WAKE;
                    end
                end
            end else if (since(now, wake_start_ms) < cfg.cooldown_ms) begin
                clear_cand();
                if (cmd_ok && it.command_label == cfg.fast_label &&
                    it.command_score >= EARLY_FAST_CONF) begin
                    hold_command(it.command_action, now, FAST_DECISION_MS);
                end
            end else if (it.is_wake_word) begin
                expire_held(now);
                if (held_due(now)) begin
                    if (run_command(it, cmd_ok, fired)) begin
                        ev = EV_FIRED;
                    end
                end else begin
                    enter_listen(now);
                    ev = EV_REFRESH;
                end
            end else if (run_command(it, cmd_ok, fired)) begin
                ev = EV_FIRED;
            end
        end
        r.wake_active      = listening;
        r.event_code       = ev;
        r.fired_action     = (ev == EV_FIRED) ? fired : 4'd0;
        r.deferred_pending = held_valid;
        return r;
    endfunction

    function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg           = CFG_RESET;
            listening     = 1'b0;
            wake_start_ms = '0;
            exit_ms       = '0;
            clear_all();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WAKE_CONFIRM:  cfg.wake_confirm_frames    = i_cfg_wdata[3:0];
                    CFG_CMD_CONFIRM:   cfg.command_confirm_frames = i_cfg_wdata[3:0];
                    CFG_COOLDOWN:      cfg.cooldown_ms            = i_cfg_wdata;
                    CFG_LISTEN_WINDOW: cfg.listen_window_ms       = i_cfg_wdata;
                    CFG_MIN_RMS:       cfg.min_rms_level          = i_cfg_wdata;
                    CFG_FAST_LABEL:    cfg.fast_label             = i_cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                seen_beat = {i_in.now_ms, i_in.has_result, i_in.is_wake_word, i_in.wake_score,
                             i_in.has_command, i_in.command_label, i_in.command_action,
                             i_in.command_score, i_in.audio_rms};
                expected_results.push_back(decide(seen_beat));
            end
            if (i_out.valid && i_out.ready) begin
                got_result = {i_out.wake_active, i_out.event_code, i_out.fired_action,
                              i_out.deferred_pending};
                if (expected_results.size() == 0) begin
                    $error("Result beat arrived with no expected result waiting.");
                    fail_total++;
                end else begin
                    want_result = expected_results.pop_front();
                    check_field("wake_active", want_result.wake_active,
                                got_result.wake_active);
                    check_field("event_code", want_result.event_code,
                                got_result.event_code);
                    check_field("fired_action", want_result.fired_action,
                                got_result.fired_action);
                    check_field("deferred_pending", want_result.deferred_pending,
                                got_result.deferred_pending);
                end
            end
        end
        o_waiting <= expected_results.size();
    end

endmodule

@@ dv/tb.sv @@
// Top of the decider testbench: clock, reset, register writes, frame stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import wcd_pkg::*;

    typedef enum int {
        RX_ALWAYS,
        RX_PATTERN,
        RX_RANDOM
    } t_rx_mode;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [15:0]             cfg_wdata;
    int                      fail_count;
    int                      waiting;

    t_rx_mode                rx_mode = RX_ALWAYS;
    logic [15:0]             rx_pattern = 16'hFFFF;
    logic [3:0]              rx_slot = '0;

    t_cfg                    phase_cfg = CFG_RESET;
    logic [31:0]             stamp_ms = 32'd20000;
    int                      burst_left = 0;
    int                      sent_count = 0;

    wcd_in_if  in_ch ();
    wcd_out_if out_ch ();

    wake_and_command_decider dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    wcd_decision_checker u_decision_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        rx_slot <= rx_slot + 4'd1;
        case (rx_mode)
            RX_ALWAYS:  out_ch.ready <= 1'b1;
            RX_PATTERN: out_ch.ready <= rx_pattern[rx_slot];
            default:    out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    function automatic t_in_item frame(logic [31:0] t, logic res, logic wake,
                                       logic [15:0] wscore, logic cmd, logic [3:0] lbl,
                                       logic [3:0] act, logic [15:0] cscore,
                                       logic [15:0] rms);
        return {t, res, wake, wscore, cmd, lbl, act, cscore, rms};
    endfunction

    function automatic t_in_item base_frame(int unsigned step_ms);
        t_in_item it;
        stamp_ms          += step_ms;
        it                = '0;
        it.now_ms         = stamp_ms;
        it.has_result     = 1'b1;
        it.wake_score     = 16'($urandom_range(0, 700));
        it.command_label  = 4'($urandom_range(0, 15));
        it.command_action = 4'($urandom_range(0, 15));
        it.command_score  = 16'($urandom());
        it.audio_rms      = 16'($urandom_range(65535, int'(phase_cfg.min_rms_level)));
        return it;
    endfunction

    function automatic t_in_item noise_frame();
        t_in_item it;
        if ($urandom_range(0, 7) == 0) begin
            stamp_ms = $urandom();
        end else begin
            stamp_ms += $urandom_range(0, 400);
        end
        it.now_ms         = stamp_ms;
        it.has_result     = 1'($urandom_range(0, 1));
        it.is_wake_word   = 1'($urandom_range(0, 1));
        it.wake_score     = 16'($urandom());
        it.has_command    = 1'($urandom_range(0, 1));
        it.command_label  = 4'($urandom_range(0, 15));
        it.command_action = 4'($urandom_range(0, 15));
        it.command_score  = 16'($urandom());
        it.audio_rms      = 16'($urandom());
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
        end
        in_ch.valid <= 1'b1;
        {in_ch.now_ms, in_ch.has_result, in_ch.is_wake_word, in_ch.wake_score,
         in_ch.has_command, in_ch.command_label, in_ch.command_action,
         in_ch.command_score, in_ch.audio_rms} <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        sent_count++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input t_cfg_idx idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg c);
        cfg_beat(CFG_WAKE_CONFIRM, 16'(c.wake_confirm_frames));
        cfg_beat(CFG_CMD_CONFIRM, 16'(c.command_confirm_frames));
        cfg_beat(CFG_COOLDOWN, c.cooldown_ms);
        cfg_beat(CFG_LISTEN_WINDOW, c.listen_window_ms);
        cfg_beat(CFG_MIN_RMS, c.min_rms_level);
        cfg_beat(CFG_FAST_LABEL, 16'(c.fast_label));
        cfg_we <= 1'b0;
        phase_cfg = c;
    endtask

    task automatic run_episode();
        t_in_item   it;
        int         n;
        int         kind;
        logic [3:0] lbl;
        n = $urandom_range(0, int'(phase_cfg.wake_confirm_frames) + 1);
        case ($urandom_range(0, 2))
            0: repeat (n) begin
                it = base_frame($urandom_range(10, 120));
                it.is_wake_word = 1'b1;
                it.wake_score   = 16'($urandom());
                send_item(it);
            end
            1: repeat (n + 1) begin
                it = base_frame($urandom_range(10, 300));
                it.wake_score = 16'($urandom_range(787, 3000));
                send_item(it);
            end
            default: begin
                it = base_frame($urandom_range(10, 120));
                it.wake_score = 16'($urandom_range(4588, 65535));
                send_item(it);
            end
        endcase
        if ($urandom_range(0, 2) == 0) begin
            it = base_frame($urandom_range(10, 100));
            it.has_command   = 1'b1;
            it.command_label = phase_cfg.fast_label;
            it.command_score = 16'($urandom_range(38011, 65535));
            send_item(it);
        end
        stamp_ms += $urandom_range(0, int'(phase_cfg.cooldown_ms));
        lbl = ($urandom_range(0, 3) == 0) ? phase_cfg.fast_label : 4'($urandom_range(0, 15));
        n   = $urandom_range(1, int'(phase_cfg.command_confirm_frames) + 1);
        repeat (n) begin
            it = base_frame($urandom_range(10, 120));
            it.has_command   = ($urandom_range(0, 7) != 0);
            it.command_label = ($urandom_range(0, 7) != 0) ? lbl : 4'($urandom_range(0, 15));
            it.is_wake_word  = ($urandom_range(0, 9) == 0);
            send_item(it);
        end
        n = $urandom_range(1, 6);
        repeat (n) begin
            it   = base_frame($urandom_range(30, 300));
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                it.audio_rms = 16'($urandom_range(0, int'(phase_cfg.min_rms_level)));
            end else if (kind < 4) begin
                it.has_result = 1'b0;
            end else if (kind == 4) begin
                it.is_wake_word = 1'b1;
            end
            send_item(it);
        end
        if ($urandom_range(0, 3) == 0) begin
            stamp_ms += $urandom_range(0, int'(phase_cfg.listen_window_ms) + 1000);
            it = base_frame(0);
            it.has_result = 1'($urandom_range(0, 1));
            send_item(it);
        end
    endtask

    // Hundreds of sub-threshold wake scores inside one hold window drive the weak
    // frame count into saturation before a wake is allowed.
    task automatic weak_flood();
        t_in_item it;
        stamp_ms += int'(phase_cfg.listen_window_ms) + 1;
        it = base_frame(0);
        it.has_result = 1'b0;
        send_item(it);
        stamp_ms += 801;
        repeat (258) begin
            it = base_frame($urandom_range(0, 1));
            it.wake_score = 16'd2293;
            send_item(it);
        end
        it = base_frame(1);
        it.wake_score = 16'd2294;
        send_item(it);
    endtask

    initial begin : stimulus
        t_cfg c;
        int   target;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_wdata    = '0;
        out_ch.ready = 1'b0;
        in_ch.valid  = 1'b0;
        {in_ch.now_ms, in_ch.has_result, in_ch.is_wake_word, in_ch.wake_score,
         in_ch.has_command, in_ch.command_label, in_ch.command_action,
         in_ch.command_score, in_ch.audio_rms} = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(frame(32'd1000, 1, 1, 0, 0, 0, 0, 0, 1000));
        send_item(frame(32'd1040, 1, 1, 0, 0, 15, 15, 65535, 65535));
        send_item(frame(32'd1100, 1, 1, 65535, 1, 0, 15, 65535, 0));
        send_item(frame(32'd1200, 1, 0, 0, 1, 0, 9, 40000, 500));
        send_item(frame(32'd1600, 1, 0, 0, 0, 0, 0, 0, 500));
        send_item(frame(32'd1700, 1, 1, 65535, 0, 0, 0, 0, 500));
        send_item(frame(32'd2500, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(frame(32'd2500, 1, 0, 65535, 0, 0, 0, 0, 500));
        send_item(frame(32'd3100, 1, 0, 0, 1, 3, 5, 1000, 500));
        send_item(frame(32'd3150, 1, 0, 0, 1, 3, 6, 1000, 500));
        send_item(frame(32'd3200, 1, 1, 0, 0, 0, 0, 0, 500));
        send_item(frame(32'd8300, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(frame(32'd9200, 1, 0, 2300, 0, 0, 0, 0, 500));
        send_item(frame(32'd9250, 1, 0, 2000, 0, 0, 0, 0, 500));
        send_item(frame(32'hFFFF_E000, 1, 0, 0, 0, 0, 0, 0, 500));
        send_item(frame(32'hFFFF_EC78, 1, 0, 65535, 0, 0, 0, 0, 500));
        send_item(frame(32'd0, 1, 0, 65535, 0, 0, 0, 0, 500));
        send_item(frame(32'd600, 1, 0, 0, 1, 2, 7, 1000, 500));
        send_item(frame(32'd650, 1, 0, 0, 1, 2, 7, 1000, 500));
        send_item(frame(32'd1600, 1, 0, 0, 0, 0, 0, 0, 0));
        send_item(frame(32'd1650, 1, 0, 0, 1, 0, 12, 50000, 500));
        send_item(frame(32'd1800, 1, 1, 0, 0, 0, 0, 0, 500));
        stamp_ms = 32'd5000;

        for (int phase = 0; phase < 8; phase++) begin
            drain();
            case (phase)
                0: c = '{4'd0, 4'd0, 16'd0, 16'd0, 16'd0, 4'd0};
                1: c = '{4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15};
                7: c = CFG_RESET;
                default: begin
                    c.wake_confirm_frames    = 4'($urandom_range(0, 4));
                    c.command_confirm_frames = 4'($urandom_range(0, 4));
                    c.cooldown_ms            = 16'($urandom_range(0, 900));
                    c.listen_window_ms       = 16'($urandom_range(300, 6000));
                    c.min_rms_level          = 16'($urandom_range(0, 400));
                    c.fast_label             = 4'($urandom_range(0, 15));
                end
            endcase
            write_cfg(c);
            rx_mode    = t_rx_mode'($urandom_range(0, 2));
            rx_pattern = 16'($urandom()) | 16'h0001;
            target     = sent_count + 12;
            while (sent_count < target) begin
                if ($urandom_range(0, 5) == 0) begin
                    send_item(noise_frame());
                end else begin
                    run_episode();
                end
            end
            if (phase == 7) begin
                weak_flood();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
